### rtl/spk_pkg.sv
// Shared types, constants and round functions for the Speck64/128 cipher.
// Used by every module under rtl; depends on nothing else.
package spk_pkg;

  localparam int unsigned ROUNDS    = 27;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BLOCK_W   = 2 * WORD_W;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned ROT_X     = 8;
  localparam int unsigned ROT_Y     = 3;
  localparam int unsigned CNT_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]     LAST_RND     = CNT_W'(ROUNDS - 1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(1);

  typedef logic [WORD_W-1:0] word_t;

  // Direction of the round-key chain: left moves keys toward cell 0
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_LEFT,
    SH_RIGHT
  } shift_e;

  typedef struct packed {
    logic   seed;    // load the schedule words from the key registers
    logic   expand;  // advance the schedule, feed a new key into the tail
    shift_e shift;
  } ks_ctl_t;

  typedef enum logic [2:0] {
    ST_SEED,
    ST_EXPAND,
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } state_e;

  // One forward round; returns {x, y}
  function automatic logic [BLOCK_W-1:0] spk_fwd(word_t x, word_t y, word_t k);
    word_t xn;
    word_t yn;
    xn = ((x >> ROT_X) | (x << (WORD_W - ROT_X))) + y;
    xn = xn ^ k;
    yn = ((y << ROT_Y) | (y >> (WORD_W - ROT_Y))) ^ xn;
    return {xn, yn};
  endfunction

  // One inverse round; returns {x, y}
  function automatic logic [BLOCK_W-1:0] spk_inv(word_t x, word_t y, word_t k);
    word_t yt;
    word_t yn;
    word_t xt;
    word_t xn;
    yt = x ^ y;
    yn = (yt >> ROT_Y) | (yt << (WORD_W - ROT_Y));
    xt = (x ^ k) - yn;
    xn = (xt << ROT_X) | (xt >> (WORD_W - ROT_X));
    return {xn, yn};
  endfunction

endpackage

### rtl/speck64_128_block_cipher.sv
// Speck64/128 block cipher, one round per clock over a chain of round-key cells.
// A block taken in ST_IDLE runs its rounds in ST_ROUND; ST_DONE loads the result.
// The next block is taken only after that load; counter and key chain serve one block.
// Key expansion (ST_SEED, ST_EXPAND) runs after reset and after each key register
// write; no input or configuration transfer is taken meanwhile.
// Reset (rst_ni low, asynchronous): key registers clear to zero, then expand.
module speck64_128_block_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spk_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [spk_pkg::KEY_W-1:0]     cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [spk_pkg::BLOCK_W-1:0]   s_axis_tdata,  // [63:0] block_in
  input  logic                          s_axis_tuser,  // [0] kind
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [spk_pkg::BLOCK_W-1:0]   m_axis_tdata   // [63:0] block_out
);
  import spk_pkg::*;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic decrypt_q;
  logic [KEY_W-1:0] key_low_q;
  logic [KEY_W-1:0] key_high_q;
  logic out_valid_q, out_valid_d;
  logic [BLOCK_W-1:0] out_data_q;

  logic cfg_fire;
  logic in_fire;
  logic key_write;
  logic rnd_load;
  logic rnd_step;
  logic out_load;
  ks_ctl_t ks_ctl;
  word_t head_key;
  word_t tail_key;
  word_t rnd_key;
  logic [BLOCK_W-1:0] rnd_block;

  assign cfg_fire  = cfg_valid_i && cfg_ready_o;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign key_write = cfg_fire && ((cfg_index_i == REG_KEY_LOW) ||
                                  (cfg_index_i == REG_KEY_HIGH));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SEED:   state_d = ST_EXPAND;
      ST_EXPAND: if (cnt_q == LAST_RND) state_d = ST_IDLE;
      ST_IDLE: begin
        if (key_write) begin
          state_d = ST_SEED;
        end else if (in_fire) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND:  if (cnt_q == LAST_RND) state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_SEED;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    cfg_ready_o   = 1'b0;
    s_axis_tready = 1'b0;
    rnd_load      = 1'b0;
    rnd_step      = 1'b0;
    out_load      = 1'b0;
    ks_ctl.seed   = 1'b0;
    ks_ctl.expand = 1'b0;
    ks_ctl.shift  = SH_HOLD;
    case (state_q)
      ST_SEED: ks_ctl.seed = 1'b1;
      ST_EXPAND: begin
        ks_ctl.expand = 1'b1;
        ks_ctl.shift  = SH_LEFT;
      end
      ST_IDLE: begin
        // configuration wins a tie with an incoming block
        cfg_ready_o   = 1'b1;
        s_axis_tready = !cfg_valid_i;
        rnd_load      = 1'b1;
      end
      ST_ROUND: begin
        rnd_step     = 1'b1;
        ks_ctl.shift = decrypt_q ? SH_RIGHT : SH_LEFT;
      end
      ST_DONE: out_load = !out_valid_q || m_axis_tready;
      default: ks_ctl.shift = SH_HOLD;
    endcase
  end

  // Round counter shared by expansion and by the rounds of encryption and decryption
  always_comb begin
    cnt_d = '0;
    if ((state_q == ST_EXPAND) || (state_q == ST_ROUND)) begin
      cnt_d = (cnt_q == LAST_RND) ? '0 : cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED;
      cnt_q       <= '0;
      key_low_q   <= '0;
      key_high_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire && (cfg_index_i == REG_KEY_LOW)) begin
        key_low_q <= cfg_data_i;
      end
      if (cfg_fire && (cfg_index_i == REG_KEY_HIGH)) begin
        key_high_q <= cfg_data_i;
      end
    end
  end

  // Payload: selector of the running block and the result register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      decrypt_q <= s_axis_tuser;
    end
    if (out_load) begin
      out_data_q <= rnd_block;
    end
  end

  spk_key_sched u_key_sched (
    .clk_i      (clk_i),
    .ctl_i      (ks_ctl),
    .key_low_i  (key_low_q),
    .key_high_i (key_high_q),
    .idx_i      (cnt_q),
    .head_key_o (head_key),
    .tail_key_o (tail_key)
  );

  // Encryption reads keys from the head, decryption from the tail
  assign rnd_key = decrypt_q ? tail_key : head_key;

  spk_round_unit u_round (
    .clk_i     (clk_i),
    .load_i    (rnd_load),
    .step_i    (rnd_step),
    .decrypt_i (decrypt_q),
    .block_i   (s_axis_tdata),
    .key_i     (rnd_key),
    .block_o   (rnd_block)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Assertions
  a_no_cfg_with_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_fire && in_fire))
    else $error("configuration and block transfer in the same cycle");

  a_key_write_seeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_write |=> (state_q == ST_SEED))
    else $error("key write did not restart the expansion");

  a_last_round_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) && (cnt_q == LAST_RND) |=> (state_q == ST_DONE))
    else $error("round sequence did not finish after the last round");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_RND)
    else $error("round counter out of range");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && out_valid_q && !m_axis_tready |=>
      (state_q == ST_DONE) && $stable(out_data_q))
    else $error("result overwritten while output stalled");

endmodule

### rtl/spk_key_cell.sv
// One cell of the round-key chain: holds a single round key.
// Depends on spk_pkg for the word type and shift directions.
module spk_key_cell (
  input  logic             clk_i,
  input  spk_pkg::shift_e  shift_i,
  input  spk_pkg::word_t   from_left_i,
  input  spk_pkg::word_t   from_right_i,
  output spk_pkg::word_t   key_o
);
  import spk_pkg::*;

  word_t key_q;
  word_t key_d;

  always_comb begin
    case (shift_i)
      SH_LEFT:  key_d = from_right_i;
      SH_RIGHT: key_d = from_left_i;
      default:  key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

### rtl/spk_key_sched.sv
// Key expansion and the circular chain of round-key cells.
// Depends on spk_pkg and spk_key_cell.
module spk_key_sched (
  input  logic                      clk_i,
  input  spk_pkg::ks_ctl_t          ctl_i,
  input  logic [spk_pkg::KEY_W-1:0] key_low_i,
  input  logic [spk_pkg::KEY_W-1:0] key_high_i,
  input  logic [spk_pkg::CNT_W-1:0] idx_i,
  output spk_pkg::word_t            head_key_o,
  output spk_pkg::word_t            tail_key_o
);
  import spk_pkg::*;

  word_t a_q, a_d;
  word_t l0_q, l0_d;
  word_t l1_q, l1_d;
  word_t l2_q, l2_d;
  logic [BLOCK_W-1:0] step;
  word_t tail_in;
  word_t cell_key [ROUNDS];

  // Schedule step: round function with the round index as key
  assign step = spk_fwd(l0_q, a_q, WORD_W'(idx_i));

  always_comb begin
    a_d  = a_q;
    l0_d = l0_q;
    l1_d = l1_q;
    l2_d = l2_q;
    if (ctl_i.seed) begin
      a_d  = key_low_i[WORD_W-1:0];
      l0_d = key_low_i[KEY_W-1:WORD_W];
      l1_d = key_high_i[WORD_W-1:0];
      l2_d = key_high_i[KEY_W-1:WORD_W];
    end else if (ctl_i.expand) begin
      // rotate the three schedule words, updated one goes to the back
      a_d  = step[WORD_W-1:0];
      l0_d = l1_q;
      l1_d = l2_q;
      l2_d = step[BLOCK_W-1:WORD_W];
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    l0_q <= l0_d;
    l1_q <= l1_d;
    l2_q <= l2_d;
  end

  // Tail takes the fresh key while expanding, else the chain wraps around
  assign tail_in = ctl_i.expand ? a_q : cell_key[0];

  for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_key[ROUNDS-1];
    end else begin : g_mid_l
      assign left_w = cell_key[i-1];
    end
    if (i == ROUNDS - 1) begin : g_last
      assign right_w = tail_in;
    end else begin : g_mid_r
      assign right_w = cell_key[i+1];
    end
    spk_key_cell u_cell (
      .clk_i        (clk_i),
      .shift_i      (ctl_i.shift),
      .from_left_i  (left_w),
      .from_right_i (right_w),
      .key_o        (cell_key[i])
    );
  end

  assign head_key_o = cell_key[0];
  assign tail_key_o = cell_key[ROUNDS-1];

endmodule

### rtl/spk_round_unit.sv
// Round datapath: holds x and y and applies one round per cycle while step_i is high.
// Depends on spk_pkg for the round functions.
module spk_round_unit (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic                        step_i,
  input  logic                        decrypt_i,
  input  logic [spk_pkg::BLOCK_W-1:0] block_i,
  input  spk_pkg::word_t              key_i,
  output logic [spk_pkg::BLOCK_W-1:0] block_o
);
  import spk_pkg::*;

  word_t x_q, x_d;
  word_t y_q, y_d;
  logic [BLOCK_W-1:0] res;

  assign res = decrypt_i ? spk_inv(x_q, y_q, key_i) : spk_fwd(x_q, y_q, key_i);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (load_i) begin
      x_d = block_i[BLOCK_W-1:WORD_W];
      y_d = block_i[WORD_W-1:0];
    end else if (step_i) begin
      x_d = res[BLOCK_W-1:WORD_W];
      y_d = res[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign block_o = {x_q, y_q};

endmodule

### tb/speck64_128_block_cipher_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Speck64/128 cipher core: key writes, encrypt and
// decrypt blocks, with a behavioral predictor and a queue of expected result blocks.
// Depends on rtl/spk_pkg.sv and rtl/speck64_128_block_cipher.sv.
module speck64_128_block_cipher_test;
  import spk_pkg::*;

  // Selector codes carried on tuser
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  // Register indexes with no register behind them: writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  localparam logic [BLOCK_W-1:0] ONES = '1;

  // Random part: four idle phases, five key settings each
  localparam int unsigned CHUNKS       = 20;
  localparam int unsigned CHUNK_ITEMS  = 95;
  localparam int unsigned PHASE_CHUNKS = 5;
  localparam int unsigned SEND_IDLE_PCT  [4] = '{0, 68, 0, 8};
  localparam int unsigned RECV_STALL_PCT [4] = '{0, 0, 68, 8};

  // A quiet stretch far longer than one block or one key expansion means the core is hung.
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {
    ROW_KEY,
    ROW_BLOCK
  } row_e;

  typedef enum logic [2:0] {
    KP_FULL,
    KP_LOW,
    KP_HIGH,
    KP_ZERO,
    KP_ONES,
    KP_SPARE
  } key_plan_e;

  typedef struct packed {
    row_e                 op;
    logic [CFG_IDX_W-1:0] idx;    // register index for key rows
    logic                 kind;   // selector for block rows
    logic [BLOCK_W-1:0]   data;   // key word or input block
    logic                 typed;  // expected block given in the row
    logic [BLOCK_W-1:0]   want;
  } row_t;

  // Directed rows. The published Speck64/128 vector is typed in; the rest go
  // through the predictor.
  localparam row_t DIRECTED [24] = '{
    // zero key straight out of reset, field extremes
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_ENC, 64'h0,                   1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_ENC, ONES,                    1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_DEC, 64'h0,                   1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_DEC, ONES,                    1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_ENC, 64'h8000_0000_0000_0001, 1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_DEC, 64'h5555_5555_aaaa_aaaa, 1'b0, 64'h0},
    // writes to unused indexes leave the schedule alone
    '{ROW_KEY,   REG_SPARE_2,  KIND_ENC, ONES,                    1'b0, 64'h0},
    '{ROW_KEY,   REG_SPARE_3,  KIND_ENC, 64'h0123_4567_89ab_cdef, 1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_ENC, 64'h0,                   1'b0, 64'h0},
    // key written in halves: the first half alone already rebuilds the schedule
    '{ROW_KEY,   REG_KEY_LOW,  KIND_ENC, 64'h0b0a_0908_0302_0100, 1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_ENC, 64'h3b72_6574_7475_432d, 1'b0, 64'h0},
    '{ROW_KEY,   REG_KEY_HIGH, KIND_ENC, 64'h1b1a_1918_1312_1110, 1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_ENC, 64'h3b72_6574_7475_432d, 1'b1,
      64'h8c6f_a548_454e_028b},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_DEC, 64'h8c6f_a548_454e_028b, 1'b1,
      64'h3b72_6574_7475_432d},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_ENC, 64'hffff_ffff_0000_0000, 1'b0, 64'h0},
    // all-ones key
    '{ROW_KEY,   REG_KEY_LOW,  KIND_ENC, ONES,                    1'b0, 64'h0},
    '{ROW_KEY,   REG_KEY_HIGH, KIND_ENC, ONES,                    1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_ENC, 64'h0,                   1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_ENC, ONES,                    1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_DEC, 64'h0,                   1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_DEC, ONES,                    1'b0, 64'h0},
    // clear the upper half only
    '{ROW_KEY,   REG_KEY_HIGH, KIND_ENC, 64'h0,                   1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_DEC, 64'h0000_0000_ffff_ffff, 1'b0, 64'h0},
    '{ROW_BLOCK, REG_KEY_LOW,  KIND_ENC, 64'hdead_beef_0123_4567, 1'b0, 64'h0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [KEY_W-1:0]     cfg_data_i  = '0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [BLOCK_W-1:0]   s_axis_tdata  = '0;   // [63:0] block_in
  logic                 s_axis_tuser  = 1'b0; // [0] kind

  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [BLOCK_W-1:0]   m_axis_tdata;         // [63:0] block_out

  // Typed expectation travels alongside the block it belongs to
  logic                 pend_typed = 1'b0;
  logic [BLOCK_W-1:0]   pend_want  = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Predictor state: key registers and the expanded schedule
  logic [KEY_W-1:0]   key_lo_q = '0;
  logic [KEY_W-1:0]   key_hi_q = '0;
  word_t              sched_key [ROUNDS];
  logic [BLOCK_W-1:0] cipher_out_q [$];
  int unsigned        err_cnt = 0;
  int unsigned        quiet_cycles = 0;

  speck64_128_block_cipher u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Rebuild the round keys from both key registers. The schedule reuses the
  // forward round with the round index as key, rotating over three words.
  function automatic void rebuild_schedule();
    word_t       a;
    word_t       l [3];
    int unsigned sel;
    int unsigned i;
    a    = key_lo_q[31:0];
    l[0] = key_lo_q[63:32];
    l[1] = key_hi_q[31:0];
    l[2] = key_hi_q[63:32];
    sel  = 0;
    for (i = 0; i + 1 < ROUNDS; i++) begin
      sched_key[i] = a;
      l[sel] = ({l[sel][7:0], l[sel][31:8]} + a) ^ word_t'(i);
      a      = {a[28:0], a[31:29]} ^ l[sel];
      sel    = (sel == 2) ? 0 : sel + 1;
    end
    sched_key[ROUNDS-1] = a;
  endfunction

  // Run all rounds forward, or the inverse rounds from the last key down
  function automatic logic [BLOCK_W-1:0] speck_crypt(logic decrypt, logic [BLOCK_W-1:0] blk);
    word_t x;
    word_t y;
    int    r;
    x = blk[63:32];
    y = blk[31:0];
    if (decrypt) begin
      for (r = ROUNDS - 1; r >= 0; r--) begin
        y = y ^ x;
        y = {y[2:0], y[31:3]};
        x = (x ^ sched_key[r]) - y;
        x = {x[23:0], x[31:24]};
      end
    end else begin
      for (r = 0; r < ROUNDS; r++) begin
        x = {x[7:0], x[31:8]} + y;
        x = x ^ sched_key[r];
        y = {y[28:0], y[31:29]} ^ x;
      end
    end
    return {x, y};
  endfunction

  // Monitor: track key writes, predict each accepted block, check each result.
  // Everything is sampled at the edge where the transfer happens.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_KEY_LOW) begin
          key_lo_q = cfg_data_i;
          rebuild_schedule();
        end else if (cfg_index_i == REG_KEY_HIGH) begin
          key_hi_q = cfg_data_i;
          rebuild_schedule();
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cipher_out_q.push_back(pend_typed ? pend_want : speck_crypt(s_axis_tuser, s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_out_q.size() == 0) begin
          $error("block_out unexpected: expected none, actual %h", m_axis_tdata);
          err_cnt++;
        end else if (m_axis_tdata !== cipher_out_q[0]) begin
          $error("block_out mismatch: expected %h, actual %h", cipher_out_q[0], m_axis_tdata);
          err_cnt++;
          void'(cipher_out_q.pop_front());
        end else begin
          void'(cipher_out_q.pop_front());
        end
      end
    end
  end

  // Receiver: stall at the rate of the current phase
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: any transfer on any channel resets the quiet count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Hold the sender off until every result is back, then write one register.
  // The wait is a do-while loop, so a block accepted on this edge is already queued.
  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (cipher_out_q.size() != 0);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one block, after a random gap; tvalid stays high afterwards so
  // back-to-back blocks never drop it.
  task automatic send_block(input logic kind, input logic [BLOCK_W-1:0] blk,
                            input logic typed, input logic [BLOCK_W-1:0] want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    s_axis_tuser  <= kind;
    pend_typed    <= typed;
    pend_want     <= want;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  initial begin
    row_t               row;
    key_plan_e          plan;
    logic               kind;
    logic [BLOCK_W-1:0] blk;
    int unsigned        i;
    int unsigned        c;
    int unsigned        n;

    // Out of reset the schedule is that of the all-zero key
    rebuild_schedule();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling
    for (i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      if (row.op == ROW_KEY) begin
        write_key(row.idx, row.data);
      end else begin
        send_block(row.kind, row.data, row.typed, row.want);
      end
    end

    // Random part: a key or spare register write at the start of each chunk, idle rates per phase
    for (c = 0; c < CHUNKS; c++) begin
      send_idle_pct  = SEND_IDLE_PCT[c / PHASE_CHUNKS];
      recv_stall_pct = RECV_STALL_PCT[c / PHASE_CHUNKS];
      plan = key_plan_e'($urandom_range(0, 5));
      case (plan)
        KP_FULL: begin
          write_key(REG_KEY_LOW,  {$urandom, $urandom});
          write_key(REG_KEY_HIGH, {$urandom, $urandom});
        end
        KP_LOW: begin
          write_key(REG_KEY_LOW, {$urandom, $urandom});
        end
        KP_HIGH: begin
          write_key(REG_KEY_HIGH, {$urandom, $urandom});
        end
        KP_ZERO: begin
          write_key(REG_KEY_LOW,  '0);
          write_key(REG_KEY_HIGH, '0);
        end
        KP_ONES: begin
          write_key(REG_KEY_LOW,  ONES);
          write_key(REG_KEY_HIGH, ONES);
        end
        default: begin
          write_key($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, {$urandom, $urandom});
        end
      endcase
      for (n = 0; n < CHUNK_ITEMS; n++) begin
        kind = 1'($urandom_range(0, 1));
        blk  = {$urandom, $urandom};
        // Mix in the extremes now and then
        if ($urandom_range(0, 19) == 0) begin
          blk = $urandom_range(0, 1) ? ONES : '0;
        end
        send_block(kind, blk, 1'b0, '0);
      end
    end

    // Drain: let every result come back, then idle a little to catch extras
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (cipher_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && cipher_out_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
